// ===== hw/rtl/tanh_pi_controller_core_assert.svh =====
// Assertion macros for the tanh PI drive controller.
`ifndef TANH_PI_CONTROLLER_CORE_ASSERT_SVH
`define TANH_PI_CONTROLLER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TPC_ASSERT_IMPL(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define TPC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define TPC_ASSERT_IMPL(lbl, prop, msg)
`define TPC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hw/rtl/tpc_pkg.sv =====
// Shared types, command struct and tanh table builder for the drive controller.
`default_nettype none
package tpc_pkg;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 20;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TARGET_LEVEL  = 3'd0,
        REG_TANH_GAIN     = 3'd1,
        REG_INTEGRAL_GAIN = 3'd2,
        REG_DEAD_BAND     = 3'd3,
        REG_DRIVE_MIN     = 3'd4,
        REG_DRIVE_MAX     = 3'd5,
        REG_DRIVE_OFFSET  = 3'd6
    } reg_idx_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_INTEG = 8'b0000_0100,
        ST_INTERP = 8'b0000_1000,
        ST_SCALE = 8'b0001_0000,
        ST_SUM   = 8'b0010_0000,
        ST_CLAMP = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic load;     // capture error at input transfer
        logic mul;      // products and half span
        logic integ;    // integral update and table lookup
        logic interp;   // interpolate tanh
        logic scale;    // half span times tanh
        logic sum;      // offset plus terms
        logic clamp;    // limit and round into output register
    } cmd_t;

    // Restoring division, used only while building constant tables.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Entry k of the tanh table in Q0.16: tanh(4k/segs).
    function automatic logic [15:0] tanh_entry(input int segs, input int k);
        logic [63:0] a;
        logic [63:0] step;
        logic [63:0] term;
        logic [63:0] y;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] t;
        a = udiv64(64'd8 << 30, 64'(segs));
        step = 64'd1 << 30;
        term = 64'd1 << 30;
        y = 64'd1 << 30;
        for (int n = 1; n <= 15; n++) begin
            term = udiv64((term * a) >> 30, 64'(n));
            if ((n % 2) == 1) begin
                step = step - term;
            end else begin
                step = step + term;
            end
        end
        for (int j = 1; j <= k; j++) begin
            y = (y * step + (64'd1 << 29)) >> 30;
        end
        num = ((64'd1 << 30) - y) << 16;
        den = (64'd1 << 30) + y;
        t = udiv64(num + (den >> 1), den);
        if (t > 64'd65535) begin
            t = 64'd65535;
        end
        return t[15:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tpc_ctrl.sv =====
// Sequencer for the drive controller: one item at a time through fixed steps.
`default_nettype none
module tpc_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output tpc_pkg::cmd_t    cmd
);
    tpc_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            tpc_pkg::ST_IDLE: begin
                cmd.load = s_valid;
                if (s_valid) state_next = tpc_pkg::ST_MUL;
            end
            tpc_pkg::ST_MUL: begin
                cmd.mul = 1'b1;
                state_next = tpc_pkg::ST_INTEG;
            end
            tpc_pkg::ST_INTEG: begin
                cmd.integ = 1'b1;
                state_next = tpc_pkg::ST_INTERP;
            end
            tpc_pkg::ST_INTERP: begin
                cmd.interp = 1'b1;
                state_next = tpc_pkg::ST_SCALE;
            end
            tpc_pkg::ST_SCALE: begin
                cmd.scale = 1'b1;
                state_next = tpc_pkg::ST_SUM;
            end
            tpc_pkg::ST_SUM: begin
                cmd.sum = 1'b1;
                state_next = tpc_pkg::ST_CLAMP;
            end
            tpc_pkg::ST_CLAMP: begin
                cmd.clamp = 1'b1;
                state_next = tpc_pkg::ST_OUT;
            end
            tpc_pkg::ST_OUT: begin
                if (m_ready) state_next = tpc_pkg::ST_IDLE;
            end
            default: state_next = tpc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tpc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == tpc_pkg::ST_IDLE);
    assign m_valid = (state_reg == tpc_pkg::ST_OUT);
endmodule
`default_nettype wire

// ===== hw/rtl/tpc_datapath.sv =====
// Arithmetic datapath: registers, error, integral, tanh lookup, output clamp.
`default_nettype none
module tpc_datapath #(
    parameter int MEAS_BITS = 12,
    parameter int TANH_SEGMENTS = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [tpc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [tpc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  wire tpc_pkg::cmd_t                         cmd,
    input  wire logic [MEAS_BITS-1:0]                  s_measured,
    output logic [15:0]                                m_drive,
    output logic                                       m_clamped
);
    localparam int EW = ((MEAS_BITS > 12) ? MEAS_BITS : 12) + 1;
    localparam int XW = EW + 21;
    localparam int IPW = EW + 17;
    localparam int SW = $clog2(TANH_SEGMENTS + 1);
    localparam int PW = 18 + SW;

    logic [15:0] tbl [TANH_SEGMENTS+1];
    for (genvar k = 0; k <= TANH_SEGMENTS; k++) begin : g_tbl
        localparam logic [15:0] TV = tpc_pkg::tanh_entry(TANH_SEGMENTS, k);
        assign tbl[k] = TV;
    end

    // configuration
    logic [11:0] target_reg;
    logic [19:0] gain_reg;
    logic [15:0] ki_reg;
    logic [11:0] band_reg;
    logic [15:0] dmin_reg, dmax_reg, doff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= 12'd2000;
            gain_reg   <= 20'd131;
            ki_reg     <= 16'd3277;
            band_reg   <= 12'd0;
            dmin_reg   <= 16'd0;
            dmax_reg   <= 16'd1000;
            doff_reg   <= 16'd500;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tpc_pkg::REG_TARGET_LEVEL:  target_reg <= cfg_data[11:0];
                tpc_pkg::REG_TANH_GAIN:     gain_reg   <= cfg_data;
                tpc_pkg::REG_INTEGRAL_GAIN: ki_reg     <= cfg_data[15:0];
                tpc_pkg::REG_DEAD_BAND:     band_reg   <= cfg_data[11:0];
                tpc_pkg::REG_DRIVE_MIN:     dmin_reg   <= cfg_data[15:0];
                tpc_pkg::REG_DRIVE_MAX:     dmax_reg   <= cfg_data[15:0];
                tpc_pkg::REG_DRIVE_OFFSET:  doff_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // error with dead band
    logic signed [EW-1:0] err_raw, err_mag;
    always_comb begin
        err_raw = $signed(EW'(target_reg)) - $signed(EW'(s_measured));
        err_mag = err_raw[EW-1] ? -err_raw : err_raw;
    end

    logic signed [EW-1:0]  err_reg;
    logic signed [IPW-1:0] iprod_reg;
    logic signed [XW-1:0]  x_reg;
    logic signed [32:0]    half_reg;
    logic signed [33:0]    integ_reg;
    logic [15:0]           lo_reg, hi_reg;
    logic [17:0]           frac_reg;
    logic                  sat_reg, neg_reg;
    logic signed [17:0]    t_reg;
    logic signed [50:0]    ht_reg;
    logic signed [39:0]    val_reg;

    // integral update and table index
    logic signed [35:0] isum, iclip;
    logic [XW-1:0]      xabs;
    logic [PW-1:0]      pos;
    logic [SW-1:0]      seg, seg_hi;
    always_comb begin
        isum = 36'(integ_reg) + 36'(iprod_reg);
        iclip = isum;
        if (iclip > 36'(half_reg)) iclip = 36'(half_reg);
        if (iclip < -36'(half_reg)) iclip = -36'(half_reg);
        xabs = x_reg[XW-1] ? XW'(-x_reg) : XW'(x_reg);
        pos = PW'(xabs[17:0]) * PW'(TANH_SEGMENTS);
        seg = pos[PW-1:18];
        if (seg > SW'(TANH_SEGMENTS - 1)) seg = SW'(TANH_SEGMENTS - 1);
        seg_hi = seg + SW'(1);
    end

    logic [16:0] tmag;
    logic [15:0] hi_fix;
    logic [33:0] dprod;
    always_comb begin
        hi_fix = (hi_reg < lo_reg) ? lo_reg : hi_reg;
        dprod = 34'(hi_fix - lo_reg) * 34'(frac_reg) + 34'(1 << 17);
        tmag = 17'(lo_reg) + 17'(dprod[33:18]);
        if (sat_reg) tmag = 17'h10000;
    end

    logic signed [39:0] ht_round, vsum, vclip;
    logic signed [39:0] lim_hi, lim_lo;
    logic               clip;
    always_comb begin
        ht_round = 40'((ht_reg + 51'sd32768) >>> 16);
        vsum = $signed({8'd0, doff_reg, 16'd0}) + ht_round + 40'(integ_reg);
        lim_hi = $signed({8'd0, dmax_reg, 16'd0});
        lim_lo = $signed({8'd0, dmin_reg, 16'd0});
        vclip = val_reg;
        clip = 1'b0;
        if (vclip > lim_hi) begin
            vclip = lim_hi;
            clip = 1'b1;
        end
        if (vclip < lim_lo) begin
            vclip = lim_lo;
            clip = 1'b1;
        end
    end

    logic signed [39:0] vround;
    assign vround = (vclip + 40'sd32768) >>> 16;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
        end else if (cmd.integ) begin
            integ_reg <= iclip[33:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            err_reg <= (err_mag < $signed(EW'(band_reg))) ? '0 : err_raw;
        end
        if (cmd.mul) begin
            iprod_reg <= IPW'(err_reg) * $signed(IPW'({1'b0, ki_reg}));
            x_reg     <= XW'(err_reg) * $signed(XW'({1'b0, gain_reg}));
            half_reg  <= (33'(dmax_reg) - 33'(dmin_reg)) <<< 15;
        end
        if (cmd.integ) begin
            sat_reg  <= xabs >= XW'(4 << 16);
            neg_reg  <= x_reg[XW-1];
            lo_reg   <= tbl[seg];
            hi_reg   <= tbl[seg_hi];
            frac_reg <= pos[17:0];
        end
        if (cmd.interp) begin
            t_reg    <= neg_reg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
        end
        if (cmd.scale) begin
            ht_reg <= 51'(half_reg) * 51'(t_reg);
        end
        if (cmd.sum) begin
            val_reg <= vsum;
        end
        if (cmd.clamp) begin
            m_drive   <= vround[15:0];
            m_clamped <= clip;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/tanh_pi_controller_core.sv =====
// From input transfer to result valid the sequencer steps through MUL, INTEG, INTERP,
// SCALE, SUM, CLAMP and OUT. It holds one item and takes no new one until the result
// has been transferred out. The chain of products, table interpolation and scaling sets these steps.
// Reset (aresetn low, synchronous): sequencer idles, integral clears,
// configuration registers return to their defaults.
`default_nettype none
`include "tanh_pi_controller_core_assert.svh"
module tanh_pi_controller_core #(
    parameter int MEAS_BITS = 12,
    parameter int TANH_SEGMENTS = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [tpc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [tpc_pkg::CFG_DATA_BITS-1:0] cfg_data,
    // measurement input
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [MEAS_BITS-1:0]              s_measured,
    // drive output
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [15:0]                            m_drive,
    output logic                                   m_clamped
);
    tpc_pkg::cmd_t cmd;

    // Sequencer: accept one transfer, step the datapath, hold the result
    // until the output transfer completes.
    tpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Datapath: registers, integral state, tanh table and clamping.
    tpc_datapath #(
        .MEAS_BITS     (MEAS_BITS),
        .TANH_SEGMENTS (TANH_SEGMENTS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .s_measured (s_measured),
        .m_drive    (m_drive),
        .m_clamped  (m_clamped)
    );

    // Never accept a new item while a result waits.
    `TPC_ASSERT_NEVER(a_no_overlap, s_ready && m_valid, "input ready while result pending")
    // An input transfer never yields a result in the next cycle.
    `TPC_ASSERT_IMPL(a_latency, (s_valid && s_ready) |=> !m_valid, "result too early")
    // After an output transfer the block is free again.
    `TPC_ASSERT_IMPL(a_release, (m_valid && m_ready) |=> s_ready, "not idle after output")
endmodule
`default_nettype wire
